// ===== sv/ptm_pkg.sv =====
`timescale 1ns / 1ps

package ptm_pkg;

  localparam int NUM_KEYS  = 8;
  localparam int STEP_W    = 23;
  localparam int HOLD_W    = 11;
  localparam int LEVEL_W   = 7;
  localparam int ROM_DEPTH = 256;
  localparam int ADDR_W    = 8;
  localparam int DAC_W     = 8;
  // eight voices of at most 64 each
  localparam int SUM_W     = 10;
  localparam int CFG_IDX_W = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // register index of note0_step; note k sits at REG_NOTE0_STEP + k
  localparam int REG_NOTE0_STEP = 0;

  localparam logic [LEVEL_W-1:0] VOICE_AMP = 7'd64;
  localparam logic [DAC_W-1:0]   DAC_MAX   = 8'd255;
  localparam logic [SUM_W-1:0]   SUM_LIMIT = 10'd255;

  localparam logic [STEP_W-1:0] STEP_RESET [NUM_KEYS] = '{
    23'd615165, 23'd690504, 23'd775058, 23'd821147,
    23'd921705, 23'd1034580, 23'd1161276, 23'd1230329
  };

  // floor(32 + 32*sin(2*pi*i/256))
  localparam logic [LEVEL_W-1:0] SINE_ROM [ROM_DEPTH] = '{
    7'd32, 7'd32, 7'd33, 7'd34, 7'd35, 7'd35, 7'd36, 7'd37,
    7'd38, 7'd39, 7'd39, 7'd40, 7'd41, 7'd42, 7'd42, 7'd43,
    7'd44, 7'd44, 7'd45, 7'd46, 7'd47, 7'd47, 7'd48, 7'd49,
    7'd49, 7'd50, 7'd51, 7'd51, 7'd52, 7'd52, 7'd53, 7'd54,
    7'd54, 7'd55, 7'd55, 7'd56, 7'd56, 7'd57, 7'd57, 7'd58,
    7'd58, 7'd59, 7'd59, 7'd59, 7'd60, 7'd60, 7'd60, 7'd61,
    7'd61, 7'd61, 7'd62, 7'd62, 7'd62, 7'd62, 7'd63, 7'd63,
    7'd63, 7'd63, 7'd63, 7'd63, 7'd63, 7'd63, 7'd63, 7'd63,
    7'd64, 7'd63, 7'd63, 7'd63, 7'd63, 7'd63, 7'd63, 7'd63,
    7'd63, 7'd63, 7'd63, 7'd62, 7'd62, 7'd62, 7'd62, 7'd61,
    7'd61, 7'd61, 7'd60, 7'd60, 7'd60, 7'd59, 7'd59, 7'd59,
    7'd58, 7'd58, 7'd57, 7'd57, 7'd56, 7'd56, 7'd55, 7'd55,
    7'd54, 7'd54, 7'd53, 7'd52, 7'd52, 7'd51, 7'd51, 7'd50,
    7'd49, 7'd49, 7'd48, 7'd47, 7'd47, 7'd46, 7'd45, 7'd44,
    7'd44, 7'd43, 7'd42, 7'd42, 7'd41, 7'd40, 7'd39, 7'd39,
    7'd38, 7'd37, 7'd36, 7'd35, 7'd35, 7'd34, 7'd33, 7'd32,
    7'd32, 7'd31, 7'd30, 7'd29, 7'd28, 7'd28, 7'd27, 7'd26,
    7'd25, 7'd24, 7'd24, 7'd23, 7'd22, 7'd21, 7'd21, 7'd20,
    7'd19, 7'd19, 7'd18, 7'd17, 7'd16, 7'd16, 7'd15, 7'd14,
    7'd14, 7'd13, 7'd12, 7'd12, 7'd11, 7'd11, 7'd10, 7'd9,
    7'd9,  7'd8,  7'd8,  7'd7,  7'd7,  7'd6,  7'd6,  7'd5,
    7'd5,  7'd4,  7'd4,  7'd4,  7'd3,  7'd3,  7'd3,  7'd2,
    7'd2,  7'd2,  7'd1,  7'd1,  7'd1,  7'd1,  7'd0,  7'd0,
    7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
    7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
    7'd0,  7'd0,  7'd0,  7'd1,  7'd1,  7'd1,  7'd1,  7'd2,
    7'd2,  7'd2,  7'd3,  7'd3,  7'd3,  7'd4,  7'd4,  7'd4,
    7'd5,  7'd5,  7'd6,  7'd6,  7'd7,  7'd7,  7'd8,  7'd8,
    7'd9,  7'd9,  7'd10, 7'd11, 7'd11, 7'd12, 7'd12, 7'd13,
    7'd14, 7'd14, 7'd15, 7'd16, 7'd16, 7'd17, 7'd18, 7'd19,
    7'd19, 7'd20, 7'd21, 7'd21, 7'd22, 7'd23, 7'd24, 7'd24,
    7'd25, 7'd26, 7'd27, 7'd28, 7'd28, 7'd29, 7'd30, 7'd31
  };

  // stage load strobes shared by all lanes, plus the mode of the item in stage 2
  typedef struct packed {
    logic ld_s1;
    logic ld_s2;
    logic ld_s3;
    logic sine_s2;
  } ptm_pipe_t;

  // output register control for the merge stage
  typedef struct packed {
    logic load;
    logic sine;
    logic pin;
  } ptm_out_ctl_t;

endpackage

// ===== sv/ptm_lane.sv =====
`timescale 1ns / 1ps

module ptm_lane #(
  parameter int LANE_ID      = 0,
  parameter int PHASE_BITS   = 24,
  parameter int SINE_ENTRIES = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ptm_pkg::ptm_pipe_t          pipe,
  input  logic                        key,
  input  logic                        step_we,
  input  logic [ptm_pkg::STEP_W-1:0]  step_data,
  output logic [ptm_pkg::LEVEL_W-1:0] level
);
  import ptm_pkg::*;

  localparam int SLOT_W      = (SINE_ENTRIES > 1) ? $clog2(SINE_ENTRIES) : 1;
  localparam int SE_W        = $clog2(SINE_ENTRIES + 1);
  localparam int PROD0_W     = PHASE_BITS + SE_W;
  // slot * 256 / SINE_ENTRIES by reciprocal, exact for slot < 1024
  localparam int RECIP_SHIFT = 29;
  localparam int RECIP       = (2**RECIP_SHIFT + SINE_ENTRIES - 1) / SINE_ENTRIES;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int PROD1_W     = SLOT_W + RECIP_W;
  localparam int ADDR_LSB    = RECIP_SHIFT - ADDR_W;
  localparam int ADD_W       = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;

  logic [STEP_W-1:0]     step;
  logic [PHASE_BITS-1:0] phase;
  logic [ADD_W-1:0]      phase_add;
  logic [PROD0_W-1:0]    prod0;
  logic [PROD1_W-1:0]    prod1;

  logic [SLOT_W-1:0] slot1;
  logic              sq1;
  logic              key1;
  logic [ADDR_W-1:0] addr2;
  logic              sq2;
  logic              key2;

  assign phase_add = ADD_W'(phase) + ADD_W'(step);
  assign prod0     = PROD0_W'(phase) * PROD0_W'(SINE_ENTRIES);
  assign prod1     = PROD1_W'(slot1) * PROD1_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= STEP_RESET[LANE_ID];
      phase <= '0;
    end else begin
      if (step_we) begin
        step <= step_data;
      end
      if (pipe.ld_s1) begin
        phase <= phase_add[PHASE_BITS-1:0];
      end
    end
  end

  // stage 1: slot of the pre-advance phase, square level
  always_ff @(posedge clk) begin
    if (pipe.ld_s1) begin
      slot1 <= prod0[PHASE_BITS +: SLOT_W];
      sq1   <= (phase != '0) && !phase[PHASE_BITS-1];
      key1  <= key;
    end
  end

  // stage 2: map the slot onto the ROM
  always_ff @(posedge clk) begin
    if (pipe.ld_s2) begin
      addr2 <= prod1[ADDR_LSB +: ADDR_W];
      sq2   <= sq1;
      key2  <= key1;
    end
  end

  // stage 3: voice level
  always_ff @(posedge clk) begin
    if (pipe.ld_s3) begin
      if (!key2) begin
        level <= '0;
      end else if (pipe.sine_s2) begin
        level <= SINE_ROM[addr2];
      end else begin
        level <= sq2 ? VOICE_AMP : '0;
      end
    end
  end

endmodule

// ===== sv/ptm_merge.sv =====
`timescale 1ns / 1ps

module ptm_merge #(
  parameter int NUM_VOICES = 8
) (
  input  logic                                        clk,
  input  ptm_pkg::ptm_out_ctl_t                       ctl,
  input  logic [NUM_VOICES-1:0][ptm_pkg::LEVEL_W-1:0] levels,
  output logic [ptm_pkg::DAC_W-1:0]                   dac_level,
  output logic                                        clipped,
  output logic                                        sine_active,
  output logic                                        tick_pin
);
  import ptm_pkg::*;

  logic [SUM_W-1:0] sum;
  logic             over;

  always_comb begin
    sum = '0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      sum = sum + SUM_W'(levels[v]);
    end
    over = sum > SUM_LIMIT;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dac_level   <= over ? DAC_MAX : sum[DAC_W-1:0];
      clipped     <= over;
      sine_active <= ctl.sine;
      tick_pin    <= ctl.pin;
    end
  end

endmodule

// ===== sv/polyphonic_tone_mixer_top.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake                      Content
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: keys_down, mode_button
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: dac_level, clipped, sine_active,
//                                               tick_pin
// cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data (note steps 0..7)
//
// One item per cycle sustained while m_axis_tready stays high; each accepted item passes in
// order through registered stages (phase/slot multiply, ROM address multiply, ROM read, lane sum with saturation).
// Four items can be in flight; s_axis_tready drops only when all four slots are full
// and m_axis_tready is low. Bubbles between stages collapse while the output stalls.
// Reset clears phases, mode, hold-off, pin and the pipeline, and reloads the default
// note steps. cfg_ready is always high.

module polyphonic_tone_mixer_top #(
  parameter int NUM_VOICES    = 8,
  parameter int PHASE_BITS    = 24,
  parameter int SINE_ENTRIES  = 256,
  parameter int HOLDOFF_TICKS = 1200
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [7:0] keys_down, [8] mode_button, [15:9] zero
  input  logic [ptm_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [7:0] dac_level, [8] clipped, [9] sine_active, [10] tick_pin, [15:11] zero
  output logic [ptm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ptm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ptm_pkg::STEP_W-1:0]           cfg_data
);
  import ptm_pkg::*;

  localparam logic [HOLD_W-1:0] HOLD_INIT = HOLD_W'(HOLDOFF_TICKS);

  logic              accept;
  logic [NUM_KEYS-1:0] keys;
  logic              button;

  logic [HOLD_W-1:0] holdoff, holdoff_next;
  logic              mode, mode_next;
  logic              pin;
  logic              v1, v2, v3, vo;
  logic              mode1, mode2, mode3;
  logic              pin1, pin2, pin3;
  logic              free_out, free3, free2, free1;
  logic              ld2, ld3, ldo;

  ptm_pipe_t    pipe;
  ptm_out_ctl_t out_ctl;

  logic [NUM_VOICES-1:0][LEVEL_W-1:0] levels;
  logic [DAC_W-1:0] dac_level;
  logic             clipped, sine_active, tick_pin;

  assign keys   = s_axis_tdata[NUM_KEYS-1:0];
  assign button = s_axis_tdata[NUM_KEYS];

  assign free_out = !vo || m_axis_tready;
  assign free3    = !v3 || free_out;
  assign free2    = !v2 || free3;
  assign free1    = !v1 || free2;
  assign ld2      = v1 && free2;
  assign ld3      = v2 && free3;
  assign ldo      = v3 && free_out;

  assign s_axis_tready = free1;
  assign accept        = s_axis_tvalid && free1;
  assign cfg_ready     = 1'b1;

  always_comb begin
    holdoff_next = holdoff;
    mode_next    = mode;
    if (holdoff != '0) begin
      holdoff_next = holdoff - HOLD_W'(1);
    end else if (button) begin
      mode_next    = !mode;
      holdoff_next = HOLD_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holdoff <= '0;
      mode    <= 1'b0;
      pin     <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      vo      <= 1'b0;
    end else begin
      if (accept) begin
        holdoff <= holdoff_next;
        mode    <= mode_next;
        pin     <= !pin;
      end
      v1 <= accept || (v1 && !ld2);
      v2 <= ld2 || (v2 && !ld3);
      v3 <= ld3 || (v3 && !ldo);
      vo <= ldo || (vo && !m_axis_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode1 <= mode_next;
      pin1  <= !pin;
    end
    if (ld2) begin
      mode2 <= mode1;
      pin2  <= pin1;
    end
    if (ld3) begin
      mode3 <= mode2;
      pin3  <= pin2;
    end
  end

  assign pipe.ld_s1   = accept;
  assign pipe.ld_s2   = ld2;
  assign pipe.ld_s3   = ld3;
  assign pipe.sine_s2 = mode2;

  for (genvar k = 0; k < NUM_VOICES; k++) begin : g_lane
    logic step_we;
    assign step_we = cfg_valid && (cfg_index == CFG_IDX_W'(REG_NOTE0_STEP + k));

    ptm_lane #(
      .LANE_ID      (k),
      .PHASE_BITS   (PHASE_BITS),
      .SINE_ENTRIES (SINE_ENTRIES)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .pipe      (pipe),
      .key       (keys[k]),
      .step_we   (step_we),
      .step_data (cfg_data),
      .level     (levels[k])
    );
  end

  assign out_ctl.load = ldo;
  assign out_ctl.sine = mode3;
  assign out_ctl.pin  = pin3;

  ptm_merge #(
    .NUM_VOICES (NUM_VOICES)
  ) u_merge (
    .clk         (clk),
    .ctl         (out_ctl),
    .levels      (levels),
    .dac_level   (dac_level),
    .clipped     (clipped),
    .sine_active (sine_active),
    .tick_pin    (tick_pin)
  );

  assign m_axis_tvalid = vo;
  assign m_axis_tdata  = {(OUT_TDATA_W - DAC_W - 3)'(0), tick_pin, sine_active, clipped,
                          dac_level};

  // a press with the hold-off expired flips the mode
  a_mode_flip: assert property (@(posedge clk) disable iff (rst)
    (accept && button && holdoff == '0) |=> (mode != $past(mode)))
    else $error("mode did not flip on an accepted press");

  // no flip while the hold-off runs
  a_holdoff_blocks: assert property (@(posedge clk) disable iff (rst)
    (accept && holdoff != '0) |=> (mode == $past(mode)))
    else $error("mode changed during hold-off");

  a_holdoff_range: assert property (@(posedge clk) disable iff (rst)
    holdoff <= HOLD_INIT)
    else $error("hold-off count above its load value");

  // a stage-3 item blocked by the output must stay put
  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !free_out) |=> v3)
    else $error("stage-3 item lost under stall");

  a_clip_sat: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && clipped) |-> (dac_level == DAC_MAX))
    else $error("clipped result not saturated");

endmodule
